FILE: src/score_sorted_box_nms_top_defines.svh
// Assertion macros for the score-sorted box suppression block.
// Included by the top level, which carries the concurrent assertions.
`ifndef SCORE_SORTED_BOX_NMS_TOP_DEFINES_SVH
`define SCORE_SORTED_BOX_NMS_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SBN_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sbn assertion failed");
`define SBN_ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("sbn assertion failed");
`else
`define SBN_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define SBN_ASSERT_NEVER(lbl, clk_s, rst_s, expr)
`endif
`endif

FILE: src/sbn_pkg.sv
// Shared types and constants of the score-sorted box suppression block.
// No dependencies.
package sbn_pkg;
  localparam int BOX_SLOTS   = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int BOX_W       = 87;
  localparam int TDATA_W     = 88;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int IOU_LAT     = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LIMIT     = 1'b1;
  localparam logic [7:0] THRESH_RESET = 8'd51;
  localparam logic [6:0] LIMIT_RESET  = 7'd64;

  typedef struct packed {
    logic [6:0]         class_index;
    logic [15:0]        confidence;
    logic signed [15:0] bottom_edge;
    logic signed [15:0] right_edge;
    logic signed [15:0] top_edge;
    logic signed [15:0] left_edge;
  } box_t;

  typedef struct packed {
    logic frame_end;
    box_t box;
  } item_t;

  typedef struct packed {
    logic start;
    box_t a;
    box_t b;
  } iou_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } iou_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_FIN,
    ST_SUP_A_CHK,
    ST_SUP_A_LD,
    ST_SUP_B_CHK,
    ST_SUP_B_LD,
    ST_SUP_WAIT,
    ST_EMIT_CHK,
    ST_EMIT_LD,
    ST_POP
  } state_t;
endpackage

FILE: src/score_sorted_box_nms_top.sv
// Score-sorted greedy box suppression: top level with configuration registers.
// Depends on sbn_pkg, sbn_queue, sbn_back, sbn_iou and the defines header.
// Usage:
//   Boxes enter on the s_ channel, one per transaction; s_tlast marks the
//   last box of a frame. Up to box_limit boxes (at most 64) are stored per
//   frame, later ones are dropped but their tlast still closes the frame.
//   On the closing box the stored boxes, held in descending score order with
//   ties in arrival order, are swept greedily: a kept box suppresses every
//   later box whose overlap exceeds iou_threshold/256 of the union. Kept
//   boxes leave on the m_ channel in score order, m_tlast on the final one.
//   A four-entry input queue decouples the s_ side from the sequencer.
//   A stored box is compared with each ranked box of lower score and with
//   the first one not lower. At the frame end the sweep sends one pair at a
//   time through the overlap pipe, which has 5 stages, and waits for it.
//   A stalled m_ side holds the single output register and the sequencer;
//   the queue keeps taking boxes until it fills. Reset (rst, synchronous)
//   empties the queue, the frame and the output, and sets iou_threshold to
//   51 and box_limit to 64. Write configuration only while the block is idle.
`include "score_sorted_box_nms_top_defines.svh"
module score_sorted_box_nms_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // left_edge, top_edge, right_edge, bottom_edge, confidence, class_index, pad
  input  logic [sbn_pkg::TDATA_W-1:0]       s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_left, out_top, out_right, out_bottom, out_score, out_class, pad
  output logic [sbn_pkg::TDATA_W-1:0]       m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_wr_en,
  input  logic [sbn_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [sbn_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  logic [7:0]        iou_threshold;
  logic [6:0]        box_limit;
  sbn_pkg::item_t    in_item, q_item;
  logic              q_valid, q_pop;
  sbn_pkg::iou_req_t iou_req;
  sbn_pkg::iou_res_t iou_res;
  sbn_pkg::box_t     out_box;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= sbn_pkg::THRESH_RESET;
      box_limit     <= sbn_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        sbn_pkg::REG_IOU_THRESHOLD: iou_threshold <= cfg_wdata;
        sbn_pkg::REG_BOX_LIMIT:     box_limit     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign in_item = {s_tlast, sbn_pkg::box_t'(s_tdata[sbn_pkg::BOX_W-1:0])};

  sbn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_item  (q_item),
    .pop       (q_pop)
  );

  sbn_iou u_iou (
    .clk    (clk),
    .rst    (rst),
    .req    (iou_req),
    .thresh (iou_threshold),
    .res    (iou_res)
  );

  sbn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .box_limit (box_limit),
    .iou_req   (iou_req),
    .iou_res   (iou_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_box   (out_box),
    .out_last  (m_tlast)
  );

  // pad the box up to whole bytes
  assign m_tdata = {{(sbn_pkg::TDATA_W - sbn_pkg::BOX_W){1'b0}}, out_box};

  `SBN_ASSERT_NEVER(a_pop_empty, clk, rst, q_pop && !q_valid)
  `SBN_ASSERT_IMPL(a_iou_latency, clk, rst, iou_res.done, $past(iou_req.start, 5))
  `SBN_ASSERT_IMPL(a_iou_single, clk, rst, iou_req.start, ##1 !iou_req.start)
endmodule

FILE: src/sbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: src/sbn_queue.sv
// Front queue: accepts input boxes and holds them for the sequencer.
// Depends on sbn_pkg.
module sbn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sbn_pkg::item_t in_item,
  output logic          out_valid,
  output sbn_pkg::item_t out_item,
  input  logic          pop
);
  sbn_pkg::item_t slots [sbn_pkg::QUEUE_DEPTH];
  logic [sbn_pkg::QPTR_W-1:0] wr_ptr;
  logic [sbn_pkg::QPTR_W-1:0] rd_ptr;
  logic [sbn_pkg::QCNT_W-1:0] count;
  logic push;

  function automatic logic [sbn_pkg::QCNT_W-1:0] QCNT_W1(input logic b);
    QCNT_W1 = {{(sbn_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign in_ready  = (count != sbn_pkg::QCNT_W'(sbn_pkg::QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W1(push) - QCNT_W1(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end
endmodule

FILE: src/sbn_iou.sv
// Pipelined overlap test: intersection, areas, union, threshold compare.
// Depends on sbn_pkg.
module sbn_iou (
  input  logic             clk,
  input  logic             rst,
  input  sbn_pkg::iou_req_t req,
  input  logic [7:0]       thresh,
  output sbn_pkg::iou_res_t res
);
  logic signed [15:0] ix1, iy1, ix2, iy2;
  logic v1, v2, v3, v4, v5;
  logic pos1, pos2, pos3, pos4, hit5;
  logic signed [16:0] iw1, ih1, wa1, ha1, wb1, hb1;
  logic signed [33:0] inter2, area_a2, area_b2;
  logic signed [33:0] inter3;
  logic signed [35:0] uni3;
  logic signed [44:0] lhs4, prod4;

  // overlap corners
  always_comb begin
    ix1 = (req.a.left_edge  > req.b.left_edge)   ? req.a.left_edge   : req.b.left_edge;
    iy1 = (req.a.top_edge   > req.b.top_edge)    ? req.a.top_edge    : req.b.top_edge;
    ix2 = (req.a.right_edge < req.b.right_edge)  ? req.a.right_edge  : req.b.right_edge;
    iy2 = (req.a.bottom_edge < req.b.bottom_edge) ? req.a.bottom_edge : req.b.bottom_edge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= req.start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    iw1 <= 17'(ix2) - 17'(ix1);
    ih1 <= 17'(iy2) - 17'(iy1);
    wa1 <= 17'(req.a.right_edge) - 17'(req.a.left_edge);
    ha1 <= 17'(req.a.bottom_edge) - 17'(req.a.top_edge);
    wb1 <= 17'(req.b.right_edge) - 17'(req.b.left_edge);
    hb1 <= 17'(req.b.bottom_edge) - 17'(req.b.top_edge);
    pos1 <= (ix2 > ix1) && (iy2 > iy1);

    inter2  <= iw1 * ih1;
    area_a2 <= wa1 * ha1;
    area_b2 <= wb1 * hb1;
    pos2    <= pos1;

    uni3   <= 36'(area_a2) + 36'(area_b2) - 36'(inter2);
    inter3 <= inter2;
    pos3   <= pos2;

    prod4 <= $signed({1'b0, thresh}) * uni3;
    lhs4  <= 45'(inter3) <<< 8;
    pos4  <= pos3;

    hit5 <= pos4 && (lhs4 > prod4);
  end

  assign res = {v5, hit5};
endmodule

FILE: src/sbn_back.sv
// Back-end sequencer: score-ordered insertion, suppression sweep, emission.
// Depends on sbn_pkg and sbn_ram.
module sbn_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sbn_pkg::item_t    q_item,
  output logic              q_pop,
  input  logic [6:0]        box_limit,
  output sbn_pkg::iou_req_t iou_req,
  input  sbn_pkg::iou_res_t iou_res,
  output logic              out_valid,
  input  logic              out_ready,
  output sbn_pkg::box_t     out_box,
  output logic              out_last
);
  localparam int N = sbn_pkg::BOX_SLOTS;
  localparam int IW = sbn_pkg::IDX_W;
  localparam int CW = sbn_pkg::CNT_W;

  sbn_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ridx, ridx_next;
  logic [CW-1:0] sidx, sidx_next;
  logic [IW-1:0] ins_pos, ins_pos_next;
  logic [N-1:0]  flags, flags_next;
  sbn_pkg::box_t a_box, a_box_next;
  sbn_pkg::box_t out_box_next;
  logic          out_valid_next, out_last_next;
  logic [CW-1:0] limit;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  sbn_pkg::box_t wr_data, rd_box;
  logic [sbn_pkg::BOX_W-1:0] rd_data;
  logic [N-1:0]  later_alive;

  sbn_ram #(.WIDTH(sbn_pkg::BOX_W), .DEPTH(N)) u_rank_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_box = sbn_pkg::box_t'(rd_data);
  assign limit  = (box_limit > CW'(N)) ? CW'(N) : box_limit;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      later_alive[k] = (CW'(k) > ridx) && (CW'(k) < count) && !flags[k];
    end
  end

  assign iou_req = {(state == sbn_pkg::ST_SUP_B_LD), a_box, rd_box};

  always_comb begin
    state_next     = state;
    count_next     = count;
    ridx_next      = ridx;
    sidx_next      = sidx;
    ins_pos_next   = ins_pos;
    flags_next     = flags;
    a_box_next     = a_box;
    out_box_next   = out_box;
    out_last_next  = out_last;
    out_valid_next = out_valid && !out_ready;
    wr_en          = 1'b0;
    wr_addr        = ins_pos;
    wr_data        = q_item.box;
    rd_addr        = ridx[IW-1:0];
    q_pop          = 1'b0;
    unique case (state)
      sbn_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (count < limit) begin
            if (count == '0) begin
              ins_pos_next = '0;
              state_next   = sbn_pkg::ST_INS_FIN;
            end else begin
              ridx_next  = count - 1'b1;
              state_next = sbn_pkg::ST_INS_RD;
            end
          end else if (q_item.frame_end) begin
            ridx_next  = '0;
            state_next = sbn_pkg::ST_SUP_A_CHK;
          end else begin
            state_next = sbn_pkg::ST_POP;
          end
        end
      end
      sbn_pkg::ST_INS_RD: begin
        state_next = sbn_pkg::ST_INS_CMP;
      end
      sbn_pkg::ST_INS_CMP: begin
        // equal scores stay ahead of the newcomer
        if (rd_box.confidence >= q_item.box.confidence) begin
          ins_pos_next = ridx[IW-1:0] + 1'b1;
          state_next   = sbn_pkg::ST_INS_FIN;
        end else begin
          wr_en   = 1'b1;
          wr_addr = ridx[IW-1:0] + 1'b1;
          wr_data = rd_box;
          if (ridx == '0) begin
            ins_pos_next = '0;
            state_next   = sbn_pkg::ST_INS_FIN;
          end else begin
            ridx_next  = ridx - 1'b1;
            state_next = sbn_pkg::ST_INS_RD;
          end
        end
      end
      sbn_pkg::ST_INS_FIN: begin
        wr_en      = 1'b1;
        count_next = count + 1'b1;
        if (q_item.frame_end) begin
          ridx_next  = '0;
          state_next = sbn_pkg::ST_SUP_A_CHK;
        end else begin
          state_next = sbn_pkg::ST_POP;
        end
      end
      sbn_pkg::ST_SUP_A_CHK: begin
        if (ridx >= count) begin
          ridx_next  = '0;
          state_next = sbn_pkg::ST_EMIT_CHK;
        end else if (flags[ridx[IW-1:0]]) begin
          ridx_next = ridx + 1'b1;
        end else begin
          state_next = sbn_pkg::ST_SUP_A_LD;
        end
      end
      sbn_pkg::ST_SUP_A_LD: begin
        a_box_next = rd_box;
        sidx_next  = ridx + 1'b1;
        state_next = sbn_pkg::ST_SUP_B_CHK;
      end
      sbn_pkg::ST_SUP_B_CHK: begin
        rd_addr = sidx[IW-1:0];
        if (sidx >= count) begin
          ridx_next  = ridx + 1'b1;
          state_next = sbn_pkg::ST_SUP_A_CHK;
        end else if (flags[sidx[IW-1:0]]) begin
          sidx_next = sidx + 1'b1;
        end else begin
          state_next = sbn_pkg::ST_SUP_B_LD;
        end
      end
      sbn_pkg::ST_SUP_B_LD: begin
        state_next = sbn_pkg::ST_SUP_WAIT;
      end
      sbn_pkg::ST_SUP_WAIT: begin
        if (iou_res.done) begin
          if (iou_res.hit) begin
            flags_next[sidx[IW-1:0]] = 1'b1;
          end
          sidx_next  = sidx + 1'b1;
          state_next = sbn_pkg::ST_SUP_B_CHK;
        end
      end
      sbn_pkg::ST_EMIT_CHK: begin
        if (ridx >= count) begin
          count_next = '0;
          flags_next = '0;
          state_next = sbn_pkg::ST_POP;
        end else if (flags[ridx[IW-1:0]]) begin
          ridx_next = ridx + 1'b1;
        end else if (!out_valid || out_ready) begin
          state_next = sbn_pkg::ST_EMIT_LD;
        end
      end
      sbn_pkg::ST_EMIT_LD: begin
        out_box_next   = rd_box;
        out_last_next  = ~|later_alive;
        out_valid_next = 1'b1;
        ridx_next      = ridx + 1'b1;
        state_next     = sbn_pkg::ST_EMIT_CHK;
      end
      sbn_pkg::ST_POP: begin
        q_pop      = 1'b1;
        state_next = sbn_pkg::ST_IDLE;
      end
      default: begin
        state_next = sbn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbn_pkg::ST_IDLE;
      count     <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      flags     <= flags_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ridx     <= ridx_next;
    sidx     <= sidx_next;
    ins_pos  <= ins_pos_next;
    a_box    <= a_box_next;
    out_box  <= out_box_next;
    out_last <= out_last_next;
  end
endmodule

FILE: dv/nms_checker.sv
// Checker for the score-sorted box suppression block: watches the box, result
// and register-write ports, predicts the kept boxes and compares them.
// Depends on sbn_pkg.
module nms_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [sbn_pkg::TDATA_W-1:0]    s_tdata,
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [sbn_pkg::TDATA_W-1:0]    m_tdata,
  input  logic                           m_tlast,
  input  logic                           cfg_wr_en,
  input  logic [sbn_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [sbn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             kept_seen
);
  typedef struct packed {
    logic          last;
    sbn_pkg::box_t box;
  } kept_t;

  sbn_pkg::box_t frame_boxes[sbn_pkg::BOX_SLOTS];
  int unsigned   rank_slot[sbn_pkg::BOX_SLOTS];
  int unsigned   n_loaded;
  logic [7:0]    iou_thresh;
  logic [6:0]    box_limit;
  kept_t         kept_q[$];

  // Exact integer overlap test, no division.
  function automatic bit too_close(sbn_pkg::box_t a, sbn_pkg::box_t b, logic [7:0] th);
    longint ix1, iy1, ix2, iy2, iw, ih, inter, area_a, area_b, uni;
    ix1 = (a.left_edge > b.left_edge) ? a.left_edge : b.left_edge;
    iy1 = (a.top_edge > b.top_edge) ? a.top_edge : b.top_edge;
    ix2 = (a.right_edge < b.right_edge) ? a.right_edge : b.right_edge;
    iy2 = (a.bottom_edge < b.bottom_edge) ? a.bottom_edge : b.bottom_edge;
    iw = ix2 - ix1;
    ih = iy2 - iy1;
    if (iw <= 0 || ih <= 0) return 1'b0;
    inter = iw * ih;
    area_a = (longint'(a.right_edge) - longint'(a.left_edge)) *
             (longint'(a.bottom_edge) - longint'(a.top_edge));
    area_b = (longint'(b.right_edge) - longint'(b.left_edge)) *
             (longint'(b.bottom_edge) - longint'(b.top_edge));
    uni = area_a + area_b - inter;
    return inter * 256 > longint'({56'd0, th}) * uni;
  endfunction

  task automatic load_box(sbn_pkg::box_t b);
    int unsigned cap, pos;
    cap = (box_limit > sbn_pkg::BOX_SLOTS) ? sbn_pkg::BOX_SLOTS : box_limit;
    if (n_loaded >= cap) return;
    frame_boxes[n_loaded] = b;
    pos = 0;
    while (pos < n_loaded && frame_boxes[rank_slot[pos]].confidence >= b.confidence)
      pos++;
    for (int unsigned r = n_loaded; r > pos; r--) rank_slot[r] = rank_slot[r-1];
    rank_slot[pos] = n_loaded;
    n_loaded++;
  endtask

  task automatic close_frame();
    bit    gone[sbn_pkg::BOX_SLOTS];
    kept_t k;
    int    first_new;
    gone = '{default: 1'b0};
    for (int r = 0; r < n_loaded; r++) begin
      if (gone[rank_slot[r]]) continue;
      for (int s = r + 1; s < n_loaded; s++)
        if (!gone[rank_slot[s]] &&
            too_close(frame_boxes[rank_slot[r]], frame_boxes[rank_slot[s]], iou_thresh))
          gone[rank_slot[s]] = 1'b1;
    end
    first_new = kept_q.size();
    for (int r = 0; r < n_loaded; r++) begin
      if (gone[rank_slot[r]]) continue;
      k.box = frame_boxes[rank_slot[r]];
      k.last = 1'b0;
      kept_q.push_back(k);
    end
    if (kept_q.size() > first_new) kept_q[kept_q.size()-1].last = 1'b1;
    n_loaded = 0;
  endtask

  always @(posedge clk) begin
    kept_t         exp_k;
    sbn_pkg::box_t got;
    if (rst) begin
      iou_thresh = sbn_pkg::THRESH_RESET;
      box_limit = sbn_pkg::LIMIT_RESET;
      n_loaded = 0;
      kept_q.delete();
      fail_count = 0;
      kept_seen = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          sbn_pkg::REG_IOU_THRESHOLD: iou_thresh = cfg_wdata;
          sbn_pkg::REG_BOX_LIMIT:     box_limit = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        load_box(sbn_pkg::box_t'(s_tdata[sbn_pkg::BOX_W-1:0]));
        if (s_tlast) close_frame();
      end
      if (m_tvalid && m_tready) begin
        got = sbn_pkg::box_t'(m_tdata[sbn_pkg::BOX_W-1:0]);
        kept_seen++;
        if (kept_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected kept box: l=%0d t=%0d r=%0d b=%0d s=%0d c=%0d last=%0b",
                     got.left_edge, got.top_edge, got.right_edge, got.bottom_edge,
                     got.confidence, got.class_index, m_tlast);
        end else begin
          exp_k = kept_q.pop_front();
          if (got.left_edge !== exp_k.box.left_edge ||
              got.top_edge !== exp_k.box.top_edge ||
              got.right_edge !== exp_k.box.right_edge ||
              got.bottom_edge !== exp_k.box.bottom_edge ||
              got.confidence !== exp_k.box.confidence ||
              got.class_index !== exp_k.box.class_index ||
              m_tlast !== exp_k.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("kept box mismatch, expected l=%0d t=%0d r=%0d b=%0d s=%0d c=%0d last=%0b",
                       exp_k.box.left_edge, exp_k.box.top_edge, exp_k.box.right_edge,
                       exp_k.box.bottom_edge, exp_k.box.confidence,
                       exp_k.box.class_index, exp_k.last);
              $display("                      actual l=%0d t=%0d r=%0d b=%0d s=%0d c=%0d last=%0b",
                       got.left_edge, got.top_edge, got.right_edge, got.bottom_edge,
                       got.confidence, got.class_index, m_tlast);
            end
          end
        end
      end
    end
    pending = kept_q.size();
  end
endmodule

FILE: dv/tb.sv
// Top of the score-sorted box suppression testbench: clock, reset, stimulus,
// flow control and verdict. Depends on sbn_pkg, score_sorted_box_nms_top and
// nms_checker.
module tb;
  localparam int STALL_LIMIT = 60000;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [sbn_pkg::TDATA_W-1:0]    s_tdata;
  logic                           s_tlast;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [sbn_pkg::TDATA_W-1:0]    m_tdata;
  logic                           m_tlast;
  logic                           cfg_wr_en;
  logic [sbn_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [sbn_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             fail_count;
  int                             pending;
  int                             kept_seen;

  // Sender and receiver controls, changed by the main sequence.
  bit gaps_on;
  int burst_left;
  int ready_mode;
  int hold_left;
  int boxes_sent;

  score_sorted_box_nms_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  nms_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .kept_seen(kept_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: a long hold-off when asked, otherwise the current stall pattern.
  initial begin
    int phase_cnt;
    m_tready = 1'b0;
    phase_cnt = 0;
    forever begin
      @(negedge clk);
      phase_cnt++;
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        case (ready_mode)
          0:       m_tready = 1'b1;
          1:       m_tready = ($urandom_range(0, 3) != 0);
          default: m_tready = (phase_cnt % 5) < 3;
        endcase
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired with %0d kept boxes outstanding", pending);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one box; entered and left at a falling edge.
  task automatic send_box(sbn_pkg::box_t b, bit last);
    if (gaps_on) begin
      if (burst_left == 0) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    s_tvalid = 1'b1;
    s_tdata = {1'b0, b};
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    boxes_sent++;
    @(negedge clk);
  endtask

  function automatic sbn_pkg::box_t mk(int l, int t, int r, int b, int s, int c);
    sbn_pkg::box_t x;
    x.left_edge = 16'(l);
    x.top_edge = 16'(t);
    x.right_edge = 16'(r);
    x.bottom_edge = 16'(b);
    x.confidence = 16'(s);
    x.class_index = 7'(c);
    return x;
  endfunction

  // Mostly well-formed boxes clustered round a centre so that suppression
  // fires; some noise boxes with fully random corners; some score ties.
  function automatic sbn_pkg::box_t rand_box(int cx, int cy);
    sbn_pkg::box_t x;
    int            x1, y1;
    if ($urandom_range(0, 7) == 0) begin
      x = sbn_pkg::box_t'(sbn_pkg::BOX_W'({$urandom, $urandom, $urandom}));
    end else begin
      x1 = cx + int'($urandom_range(0, 400)) - 200;
      y1 = cy + int'($urandom_range(0, 400)) - 200;
      x = mk(x1, y1, x1 + int'($urandom_range(1, 400)), y1 + int'($urandom_range(1, 400)),
             $urandom_range(0, 65535), $urandom_range(0, 127));
    end
    if ($urandom_range(0, 3) == 0) x.confidence = $urandom_range(0, 1) ? 16'd40000 : 16'd20000;
    return x;
  endfunction

  task automatic send_frame(int n);
    int cx, cy;
    cx = int'($urandom_range(0, 40000)) - 20000;
    cy = int'($urandom_range(0, 40000)) - 20000;
    for (int i = 0; i < n; i++) send_box(rand_box(cx, cy), i == n - 1);
  endtask

  // Hold the sender until every kept box is back and the block has settled.
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [sbn_pkg::CFG_IDX_W-1:0] idx,
                           logic [sbn_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = sbn_pkg::REG_IOU_THRESHOLD;
    cfg_wdata = '0;
    gaps_on = 1'b0;
    burst_left = 0;
    ready_mode = 0;
    hold_left = 0;
    boxes_sent = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: extreme corners, an identical tie, inverted and empty
    // boxes, a pair above the threshold, then a single-box frame.
    send_box(mk(-32768, -32768, 32767, 32767, 65535, 127), 1'b0);
    send_box(mk(-32768, -32768, 32767, 32767, 65535, 0), 1'b0);
    send_box(mk(100, 100, -100, -100, 0, 5), 1'b0);
    send_box(mk(50, 50, 50, 90, 300, 1), 1'b0);
    send_box(mk(0, 0, 160, 160, 50000, 3), 1'b0);
    send_box(mk(80, 0, 240, 160, 49999, 4), 1'b1);
    send_box(mk(-32768, 0, 0, 32767, 0, 0), 1'b1);
    drain();

    // Threshold zero: touching boxes survive, any positive overlap suppresses.
    write_reg(sbn_pkg::REG_IOU_THRESHOLD, 8'd0);
    send_box(mk(0, 0, 16, 16, 100, 1), 1'b0);
    send_box(mk(16, 0, 32, 16, 200, 2), 1'b0);
    send_box(mk(31, 15, 48, 48, 300, 3), 1'b1);
    gaps_on = 1'b1;
    ready_mode = 1;
    repeat (4) send_frame($urandom_range(2, 8));
    drain();

    // Top threshold with a small limit: over-limit boxes are dropped.
    write_reg(sbn_pkg::REG_IOU_THRESHOLD, 8'd255);
    write_reg(sbn_pkg::REG_BOX_LIMIT, 8'd5);
    send_box(mk(10, 10, 90, 90, 7, 9), 1'b0);
    send_box(mk(10, 10, 90, 90, 7, 10), 1'b1);
    ready_mode = 2;
    repeat (3) send_frame(8);
    drain();

    // Limit of one, then limit zero where every frame comes back empty.
    write_reg(sbn_pkg::REG_IOU_THRESHOLD, 8'd128);
    write_reg(sbn_pkg::REG_BOX_LIMIT, 8'd1);
    repeat (3) send_frame($urandom_range(1, 4));
    drain();
    write_reg(sbn_pkg::REG_BOX_LIMIT, 8'd0);
    repeat (3) send_frame(2);
    drain();

    // Limit above the store size saturates; one frame overfills it.
    write_reg(sbn_pkg::REG_IOU_THRESHOLD, 8'd77);
    write_reg(sbn_pkg::REG_BOX_LIMIT, 8'd100);
    ready_mode = 1;
    send_frame(70);
    drain();

    // Long receiver hold-off while boxes keep coming: the input queue fills.
    write_reg(sbn_pkg::REG_BOX_LIMIT, 8'd64);
    gaps_on = 1'b0;
    hold_left = 400;
    send_frame(8);
    send_frame(10);
    drain();

    // Random tail: mixed thresholds, bursts and stall patterns.
    gaps_on = 1'b1;
    do begin
      write_reg(sbn_pkg::REG_IOU_THRESHOLD, 8'($urandom_range(0, 255)));
      ready_mode = $urandom_range(0, 2);
      repeat (2) send_frame($urandom_range(1, 8));
      drain();
    end while (boxes_sent < 150);

    $display("sent %0d boxes and checked %0d kept boxes over thresholds 0 to 255",
             boxes_sent, kept_seen);
    $display("and box limits 0, 1, 5, 64 and 100, with stalls on both sides");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
